// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared result codes of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	typedef logic [2:0] kind_t;

	// result kinds
	localparam kind_t KIND_DATA       = 3'd0;
	localparam kind_t KIND_EMPTY_END  = 3'd1;
	localparam kind_t KIND_PING       = 3'd2;
	localparam kind_t KIND_CLOSE      = 3'd3;
	localparam kind_t KIND_BAD_OPCODE = 3'd4;
	localparam kind_t KIND_TOO_LONG   = 3'd5;

	// frame opcodes
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	// 7-bit length codes that select an extended length
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam int unsigned MAX_LEN_W = 31;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 31'h7fff_ffff;

endpackage

// ===== rtl/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side websocket frame parser, one byte per request.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while results are taken and returns at
// most one result per byte. A byte sits in the input register, is parsed
// there against the frame state, and its result (if any) lands in the output
// register; the block sustains one byte per clock for as long as the output
// side keeps taking results. The per-byte state update (a 64-bit length
// shift, decrement and limit compare) lies between the two registers. Data
// payload bytes come out unmasked; empty FIN data frames, pings and closes
// give one event each. A bad opcode or a length above the max_len_q limit
// gives an error result, after which every byte is taken and dropped until
// reset. The limit is written through cfg_wr_en / cfg_wr_data; the user is
// to write it only while the block is idle, which the block does not enforce.

module websocket_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	// byte stream in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// results out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic        end_of_message
);

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXT     = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_HALT    = 3'd5;

	function automatic logic op_is_data(input logic [3:0] op);
		return op <= wsd_pkg::OP_BINARY;
	endfunction

	function automatic logic op_supported(input logic [3:0] op);
		return (op <= wsd_pkg::OP_BINARY) || (op == wsd_pkg::OP_CLOSE)
			|| (op == wsd_pkg::OP_PING);
	endfunction

	// configuration
	logic [30:0] max_len_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	logic [2:0]  phase_q, phase_d;
	logic [7:0]  hdr_first_q, hdr_first_d;
	logic        masked_q, masked_d;
	logic [3:0]  ext_left_q, ext_left_d;
	logic [63:0] accum_q, accum_d;
	logic [31:0] mask_key_q, mask_key_d;
	logic [1:0]  mask_pos_q, mask_pos_d;
	logic [63:0] pay_left_q, pay_left_d;

	// output register
	logic              out_valid_q;
	wsd_pkg::kind_t    kind_q;
	logic [7:0]        data_q;
	logic              eom_q;

	// parse result
	logic           res_valid;
	wsd_pkg::kind_t res_kind;
	logic [7:0]     res_data;
	logic           res_eom;

	logic       fire;
	logic       len_done;
	logic       hdr_done;
	logic       too_long;
	logic       last_byte;
	logic [7:0] key_byte;
	logic [3:0] op;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	assign op        = hdr_first_q[3:0];
	assign last_byte = (pay_left_q == 64'd1);

	always_comb begin
		unique case (mask_pos_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		hdr_first_d = hdr_first_q;
		masked_d    = masked_q;
		ext_left_d  = ext_left_q;
		accum_d     = accum_q;
		mask_key_d  = mask_key_q;
		mask_pos_d  = mask_pos_q;
		pay_left_d  = pay_left_q;
		res_valid   = 1'b0;
		res_kind    = wsd_pkg::KIND_DATA;
		res_data    = 8'd0;
		res_eom     = 1'b0;
		len_done    = 1'b0;
		hdr_done    = 1'b0;
		too_long    = 1'b0;

		unique case (phase_q)
			PH_HDR0: begin
				hdr_first_d = byte_s1;
				phase_d     = PH_HDR1;
			end
			PH_HDR1: begin
				masked_d   = byte_s1[7];
				mask_key_d = 32'd0;
				mask_pos_d = 2'd0;
				if (byte_s1[6:0] == wsd_pkg::LEN7_EXT16
						|| byte_s1[6:0] == wsd_pkg::LEN7_EXT64) begin
					ext_left_d = (byte_s1[6:0] == wsd_pkg::LEN7_EXT16) ? 4'd2 : 4'd8;
					accum_d    = 64'd0;
					phase_d    = PH_EXT;
				end else begin
					accum_d  = {57'd0, byte_s1[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				accum_d    = {accum_q[55:0], byte_s1};
				ext_left_d = ext_left_q - 4'd1;
				len_done   = (ext_left_d == 4'd0);
			end
			PH_MASK: begin
				mask_key_d = {mask_key_q[23:0], byte_s1};
				ext_left_d = ext_left_q - 4'd1;
				hdr_done   = (ext_left_d == 4'd0);
			end
			PH_PAYLOAD: begin
				mask_pos_d = mask_pos_q + 2'd1;
				pay_left_d = pay_left_q - 64'd1;
				if (last_byte) begin
					phase_d = PH_HDR0;
				end
				if (op_is_data(op)) begin
					res_valid = 1'b1;
					res_kind  = wsd_pkg::KIND_DATA;
					res_data  = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
					res_eom   = last_byte && hdr_first_q[7];
				end else if (last_byte) begin
					res_valid = 1'b1;
					res_kind  = (op == wsd_pkg::OP_PING) ? wsd_pkg::KIND_PING
						: wsd_pkg::KIND_CLOSE;
				end
			end
			default: begin
				// halted, unused codes too
			end
		endcase

		// length field complete: opcode and limit checks
		if (len_done) begin
			too_long = (accum_d[63:31] != 33'd0) || (accum_d[30:0] > max_len_q);
			if (!op_supported(op)) begin
				phase_d   = PH_HALT;
				res_valid = 1'b1;
				res_kind  = wsd_pkg::KIND_BAD_OPCODE;
			end else if (too_long) begin
				phase_d   = PH_HALT;
				res_valid = 1'b1;
				res_kind  = wsd_pkg::KIND_TOO_LONG;
			end else if (masked_d) begin
				ext_left_d = 4'd4;
				phase_d    = PH_MASK;
			end else begin
				hdr_done = 1'b1;
			end
		end

		// header complete: payload or zero-length frame event
		if (hdr_done) begin
			pay_left_d = accum_d;
			mask_pos_d = 2'd0;
			if (accum_d != 64'd0) begin
				phase_d = PH_PAYLOAD;
			end else begin
				phase_d = PH_HDR0;
				if (op_is_data(op)) begin
					res_valid = hdr_first_q[7];
					res_kind  = wsd_pkg::KIND_EMPTY_END;
				end else begin
					res_valid = 1'b1;
					res_kind  = (op == wsd_pkg::OP_PING) ? wsd_pkg::KIND_PING
						: wsd_pkg::KIND_CLOSE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= wsd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			hdr_first_q <= 8'd0;
			masked_q    <= 1'b0;
			ext_left_q  <= 4'd0;
			accum_q     <= 64'd0;
			mask_key_q  <= 32'd0;
			mask_pos_q  <= 2'd0;
			pay_left_q  <= 64'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			hdr_first_q <= hdr_first_d;
			masked_q    <= masked_d;
			ext_left_q  <= ext_left_d;
			accum_q     <= accum_d;
			mask_key_q  <= mask_key_d;
			mask_pos_q  <= mask_pos_d;
			pay_left_q  <= pay_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_q <= res_kind;
			data_q <= res_data;
			eom_q  <= res_eom;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_q;
	assign end_of_message = eom_q;

endmodule

// ===== rtl/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the websocket frame deframer, bound into websocket_frame_deframer_core.
// ----------------------------------------------------------------------------
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] kind,
	input logic [7:0] data_byte,
	input logic       end_of_message
);

	logic halted_q;
	logic err_taken;

	assign err_taken = out_valid && out_ready &&
		(kind == wsd_pkg::KIND_BAD_OPCODE || kind == wsd_pkg::KIND_TOO_LONG);

	// remembers that an error was delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (err_taken) begin
			halted_q <= 1'b1;
		end
	end

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= wsd_pkg::KIND_TOO_LONG)
		else $error("result kind out of range");

	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != wsd_pkg::KIND_DATA) |-> (data_byte == 8'd0 && !end_of_message))
		else $error("event result carries payload bits");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !out_valid)
		else $error("result after error halt");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(end_of_message)))
		else $error("stalled result changed");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.data_byte      (data_byte),
	.end_of_message (end_of_message)
);
